// ----- design/rks_pkg.sv -----
`timescale 1ns / 1ps

package rks_pkg;

	// widths fixed by the item format
	localparam int DRAW_W   = 10;
	localparam int CFG_W    = 11;
	localparam int STATUS_W = 2;

	// values reachable by a draw
	localparam int DRAW_SPAN = 1 << DRAW_W;

	// generation tag kept next to each permutation entry
	localparam int EPOCH_W = 8;
	localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
	localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

	// shuffle when k exceeds n / CUTOFF_DIV
	localparam int CUTOFF_DIV = 3;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_SET_SIZE   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_PICK_COUNT = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_PICKED = 2'd0,
		ST_RANGE  = 2'd1,
		ST_DONE   = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_EXEC
	} fsm_t;

endpackage

// ----- design/rks_in_if.sv -----
`timescale 1ns / 1ps

interface rks_in_if import rks_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              start_req;
	logic [DRAW_W-1:0] draw;

	modport source (output valid, output start_req, output draw, input ready);
	modport sink (input valid, input start_req, input draw, output ready);
endinterface

// ----- design/rks_out_if.sv -----
`timescale 1ns / 1ps

interface rks_out_if import rks_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [DRAW_W-1:0]   picked_value;
	logic [DRAW_W-1:0]   pick_position;
	logic                last_pick;
	logic [STATUS_W-1:0] status;

	modport source (output valid, output picked_value, output pick_position,
		output last_pick, output status, input ready);
	modport sink (input valid, input picked_value, input pick_position,
		input last_pick, input status, output ready);
endinterface

// ----- design/random_k_of_n_sampler.sv -----
`timescale 1ns / 1ps
// an accepted item is read from the entry memory, then decoded in EXEC into the output register
// a new item is taken only in IDLE, after the read then write-back of the entry memory for the last one
// a start that exhausts the generation tags first sweeps the tags, then rereads the entries
// reset: asynchronous, active low; then a sweep over all min(MAX_SET, 1024) entries clears the
// generation tags before the first item is taken; config writes are taken throughout

module random_k_of_n_sampler import rks_pkg::*; #(
	parameter int MAX_SET = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	rks_in_if.sink               in_ch,
	rks_out_if.source            out_ch
);

	// only entries below the draw span can ever be addressed
	localparam int DEPTH  = (MAX_SET < DRAW_SPAN) ? MAX_SET : DRAW_SPAN;
	localparam int AW     = $clog2(DEPTH);
	localparam int WORD_W = EPOCH_W + DRAW_W;
	// cap on n; set_size above what 11 bits hold never needs clipping
	localparam int CAP_INT = (MAX_SET > (1 << CFG_W) - 1) ? (1 << CFG_W) - 1 : MAX_SET;
	localparam logic [CFG_W-1:0] CAP_N = CFG_W'(CAP_INT);
	localparam int PROD_W = CFG_W + 2;

	// configuration
	logic [CFG_W-1:0] set_size_q;
	logic [CFG_W-1:0] pick_count_q;

	// control state
	fsm_t              state_q, state_d;
	logic              shuf_q;
	logic [CFG_W-1:0]  picked_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic [AW-1:0]     clr_addr_q;
	logic              pend_q;
	logic              out_valid_q;

	// payload
	logic [DRAW_W-1:0] draw_q;
	logic [DRAW_W-1:0] val_q;
	logic [DRAW_W-1:0] pos_q;
	logic              last_q;
	status_t           status_q;

	// memory port signals
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [WORD_W-1:0] ram_wdata;
	logic [AW-1:0]     ram_raddr_a;
	logic [AW-1:0]     ram_raddr_b;
	logic [WORD_W-1:0] ram_rdata_a;
	logic [WORD_W-1:0] ram_rdata_b;

	// effective n and k, read live every item
	logic [CFG_W-1:0]  n_eff;
	logic [CFG_W-1:0]  k_eff;
	logic [PROD_W-1:0] k_times;
	logic              mode_new;

	logic              in_fire;
	logic              start_wrap;

	// execute stage decode
	logic              hit_a;
	logic              hit_b;
	logic [DRAW_W-1:0] val_d;
	logic [DRAW_W-1:0] val_p;
	logic [CFG_W-1:0]  d_ext;
	logic [CFG_W-1:0]  picked_inc;
	logic              all_done;
	logic              range_bad;
	logic              has_res;
	logic              do_pick;
	logic              stall;
	logic              exec_go;
	logic [DRAW_W-1:0] res_val;
	status_t           res_status;

	assign n_eff = (set_size_q == '0) ? CFG_W'(1) :
		((set_size_q > CAP_N) ? CAP_N : set_size_q);
	assign k_eff = (pick_count_q > n_eff) ? n_eff : pick_count_q;
	// k > floor(n/3) is the same test as 3k > n
	assign k_times  = PROD_W'(k_eff) * PROD_W'(CUTOFF_DIV);
	assign mode_new = (k_eff == n_eff) || (k_times > PROD_W'(n_eff));

	assign in_ch.ready = (state_q == S_IDLE);
	assign in_fire     = in_ch.valid && in_ch.ready;
	// a start at the last tag value needs the tags swept back to zero
	assign start_wrap  = in_ch.start_req && (epoch_q == EPOCH_LAST);

	// read both the draw entry and the current pick position entry
	always_comb begin
		if (state_q == S_IDLE) begin
			ram_raddr_a = in_ch.draw[AW-1:0];
			ram_raddr_b = in_ch.start_req ? '0 : picked_q[AW-1:0];
		end else begin
			ram_raddr_a = draw_q[AW-1:0];
			ram_raddr_b = picked_q[AW-1:0];
		end
	end

	// an entry whose tag is not the current generation still holds its own index
	assign hit_a = (ram_rdata_a[DRAW_W +: EPOCH_W] == epoch_q);
	assign hit_b = (ram_rdata_b[DRAW_W +: EPOCH_W] == epoch_q);
	assign val_d = hit_a ? ram_rdata_a[DRAW_W-1:0] : draw_q;
	assign val_p = hit_b ? ram_rdata_b[DRAW_W-1:0] : picked_q[DRAW_W-1:0];

	assign d_ext      = CFG_W'(draw_q);
	assign picked_inc = picked_q + CFG_W'(1);
	assign all_done   = (picked_q >= k_eff);
	assign range_bad  = shuf_q ? ((d_ext < picked_q) || (d_ext >= n_eff)) : (d_ext >= n_eff);

	always_comb begin
		has_res    = 1'b1;
		do_pick    = 1'b0;
		res_val    = '0;
		res_status = ST_PICKED;
		if (all_done) begin
			res_status = ST_DONE;
		end else if (range_bad) begin
			res_status = ST_RANGE;
		end else if (shuf_q) begin
			do_pick = 1'b1;
			res_val = val_d;
		end else if (hit_a) begin
			// repeated draw in rejection mode: nothing comes out
			has_res = 1'b0;
		end else begin
			do_pick = 1'b1;
			res_val = draw_q;
		end
	end

	// the output register may still hold an untaken result
	assign stall   = has_res && out_valid_q && !out_ch.ready;
	assign exec_go = (state_q == S_EXEC) && !stall;

	// write port: tag sweep, or the write-back at the draw entry (swap when shuffling, mark when rejecting)
	always_comb begin
		if (state_q == S_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = exec_go && do_pick;
			ram_waddr = draw_q[AW-1:0];
			// pick position entries are final, so only the draw entry is written
			ram_wdata = {epoch_q, (shuf_q ? val_p : draw_q)};
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_addr_q == AW'(DEPTH - 1)) begin
					state_d = pend_q ? S_READ : S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_fire) begin
					state_d = start_wrap ? S_CLEAR : S_EXEC;
				end
			end
			S_READ: begin
				state_d = S_EXEC;
			end
			S_EXEC: begin
				if (!stall) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_size_q   <= CFG_W'(DRAW_SPAN);
			pick_count_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SET_SIZE:   set_size_q   <= cfg_wdata;
				REG_PICK_COUNT: pick_count_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// sampler control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shuf_q     <= 1'b0;
			picked_q   <= '0;
			epoch_q    <= EPOCH_FIRST;
			clr_addr_q <= '0;
			pend_q     <= 1'b0;
		end else begin
			if (state_q == S_CLEAR) begin
				clr_addr_q <= clr_addr_q + AW'(1);
				if (clr_addr_q == AW'(DEPTH - 1)) begin
					pend_q <= 1'b0;
				end
			end
			if (in_fire && in_ch.start_req) begin
				// restart: new tag generation means identity and empty marks
				picked_q <= '0;
				shuf_q   <= mode_new;
				if (start_wrap) begin
					epoch_q    <= EPOCH_FIRST;
					clr_addr_q <= '0;
					pend_q     <= 1'b1;
				end else begin
					epoch_q <= epoch_q + EPOCH_W'(1);
				end
			end
			if (exec_go && do_pick) begin
				picked_q <= picked_inc;
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec_go && has_res) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			draw_q <= in_ch.draw;
		end
		if (exec_go && has_res) begin
			val_q    <= res_val;
			pos_q    <= do_pick ? picked_q[DRAW_W-1:0] : '0;
			last_q   <= do_pick && (picked_inc == k_eff);
			status_q <= res_status;
		end
	end

	rks_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.raddr_a (ram_raddr_a),
		.raddr_b (ram_raddr_b),
		.rdata_a (ram_rdata_a),
		.rdata_b (ram_rdata_b)
	);

	assign out_ch.valid         = out_valid_q;
	assign out_ch.picked_value  = val_q;
	assign out_ch.pick_position = pos_q;
	assign out_ch.last_pick     = last_q;
	assign out_ch.status        = status_q;

endmodule

// ----- design/rks_ram.sv -----
`timescale 1ns / 1ps

module rks_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule
